FILE: hw/rtl/priority_slot_queue_with_eviction_top_macros.svh
// Assertion helpers for the priority slot queue.
`ifndef PRIORITY_SLOT_QUEUE_WITH_EVICTION_TOP_MACROS_SVH
`define PRIORITY_SLOT_QUEUE_WITH_EVICTION_TOP_MACROS_SVH

// Check a property on a given clock with an active-low reset.
`define PSQ_ASSERT_AT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the block clock and reset.
`define PSQ_ASSERT(label, prop, msg) \
    `PSQ_ASSERT_AT(label, aclk, aresetn, prop, msg)

`endif

FILE: hw/rtl/psq_pkg.sv
package psq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 8;
    localparam int DEFAULT_HANDLE_BITS = 16;

    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] KIND_STREAM  = 2'd2;
    localparam logic [1:0] KIND_INVALID = 2'd3;

    typedef struct packed {
        logic        ok;
        logic [1:0]  kind;
        logic [31:0] age;
    } rank_t;

    typedef struct packed {
        logic wr;
        logic rm;
        logic clr;
    } ctl_t;

endpackage

FILE: hw/rtl/psq_cell.sv
module psq_cell #(
    parameter int QUEUE_DEPTH = psq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int HANDLE_BITS = psq_pkg::DEFAULT_HANDLE_BITS,
    parameter int CELL_IDX    = 0,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   sel,
    input  psq_pkg::ctl_t          ctl,
    input  logic [1:0]             wr_kind,
    input  logic [31:0]            wr_stamp,
    input  logic [31:0]            wr_corr,
    input  logic [31:0]            wr_seq,
    input  logic [HANDLE_BITS-1:0] wr_handle,
    input  logic [31:0]            now_stamp,
    input  logic                   free_ok_i,
    input  logic [IDX_W-1:0]       free_idx_i,
    input  psq_pkg::rank_t         hi_i,
    input  logic [IDX_W-1:0]       hi_idx_i,
    input  logic [31:0]            hi_corr_i,
    input  logic [31:0]            hi_seq_i,
    input  logic [HANDLE_BITS-1:0] hi_handle_i,
    input  psq_pkg::rank_t         lo_i,
    input  logic [IDX_W-1:0]       lo_idx_i,
    output logic                   free_ok_o,
    output logic [IDX_W-1:0]       free_idx_o,
    output psq_pkg::rank_t         hi_o,
    output logic [IDX_W-1:0]       hi_idx_o,
    output logic [31:0]            hi_corr_o,
    output logic [31:0]            hi_seq_o,
    output logic [HANDLE_BITS-1:0] hi_handle_o,
    output psq_pkg::rank_t         lo_o,
    output logic [IDX_W-1:0]       lo_idx_o
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic                   valid_reg;
    logic [1:0]             kind_reg;
    logic [31:0]            stamp_reg;
    logic [31:0]            corr_reg;
    logic [31:0]            seq_reg;
    logic [HANDLE_BITS-1:0] handle_reg;

    logic                   free_ok_reg;
    logic [IDX_W-1:0]       free_idx_reg;
    psq_pkg::rank_t         hi_reg;
    logic [IDX_W-1:0]       hi_idx_reg;
    logic [31:0]            hi_corr_reg;
    logic [31:0]            hi_seq_reg;
    logic [HANDLE_BITS-1:0] hi_handle_reg;
    psq_pkg::rank_t         lo_reg;
    logic [IDX_W-1:0]       lo_idx_reg;

    logic [31:0] age;
    logic        take_free;
    logic        take_hi;
    logic        take_lo;

    always_comb begin
        age       = now_stamp - stamp_reg;
        take_free = !free_ok_i && !valid_reg;
        take_hi   = valid_reg && (!hi_i.ok || (kind_reg < hi_i.kind) ||
                    ((kind_reg == hi_i.kind) && (age > hi_i.age)));
        take_lo   = valid_reg && (!lo_i.ok || (kind_reg > lo_i.kind) ||
                    ((kind_reg == lo_i.kind) && (age > lo_i.age)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.clr) begin
            valid_reg <= 1'b0;
        end else if (sel && ctl.wr) begin
            valid_reg <= 1'b1;
        end else if (sel && ctl.rm) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (sel && ctl.wr) begin
            kind_reg   <= wr_kind;
            stamp_reg  <= wr_stamp;
            corr_reg   <= wr_corr;
            seq_reg    <= wr_seq;
            handle_reg <= wr_handle;
        end
    end

    // advance the candidates one cell down the row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_ok_reg <= 1'b0;
            hi_reg.ok   <= 1'b0;
            lo_reg.ok   <= 1'b0;
        end else begin
            free_ok_reg <= free_ok_i || take_free;
            hi_reg.ok   <= hi_i.ok || take_hi;
            lo_reg.ok   <= lo_i.ok || take_lo;
        end
        free_idx_reg <= take_free ? MY_IDX : free_idx_i;
        if (take_hi) begin
            hi_reg.kind   <= kind_reg;
            hi_reg.age    <= age;
            hi_idx_reg    <= MY_IDX;
            hi_corr_reg   <= corr_reg;
            hi_seq_reg    <= seq_reg;
            hi_handle_reg <= handle_reg;
        end else begin
            hi_reg.kind   <= hi_i.kind;
            hi_reg.age    <= hi_i.age;
            hi_idx_reg    <= hi_idx_i;
            hi_corr_reg   <= hi_corr_i;
            hi_seq_reg    <= hi_seq_i;
            hi_handle_reg <= hi_handle_i;
        end
        if (take_lo) begin
            lo_reg.kind <= kind_reg;
            lo_reg.age  <= age;
            lo_idx_reg  <= MY_IDX;
        end else begin
            lo_reg.kind <= lo_i.kind;
            lo_reg.age  <= lo_i.age;
            lo_idx_reg  <= lo_idx_i;
        end
    end

    assign free_ok_o   = free_ok_reg;
    assign free_idx_o  = free_idx_reg;
    assign hi_o        = hi_reg;
    assign hi_idx_o    = hi_idx_reg;
    assign hi_corr_o   = hi_corr_reg;
    assign hi_seq_o    = hi_seq_reg;
    assign hi_handle_o = hi_handle_reg;
    assign lo_o        = lo_reg;
    assign lo_idx_o    = lo_idx_reg;

endmodule

FILE: hw/rtl/priority_slot_queue_with_eviction_top.sv
// Channel  Ports  Handshake          Payload
// input    s_*    s_valid / s_ready  command, frame kind, correlation, seq/status, handle
// result   m_*    m_valid / m_ready  success, displaced, popped frame, occupancy, drops
//
// Each item goes through accept, a sweep of the best, eviction and free
// candidates along the row of QUEUE_DEPTH slot cells, then apply.
// A new item is taken while the previous result still waits in the output
// register; apply holds until that register is free.
// Synchronous active-low reset empties all slots and zeroes stamp and drops.
module priority_slot_queue_with_eviction_top #(
    parameter int QUEUE_DEPTH = psq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int HANDLE_BITS = psq_pkg::DEFAULT_HANDLE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [1:0]  s_frame_kind,
    input  logic [31:0] s_frame_correlation,
    input  logic [31:0] s_frame_seq_status,
    input  logic [15:0] s_frame_handle,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_success,
    output logic        m_displaced,
    output logic [1:0]  m_out_kind,
    output logic [31:0] m_out_correlation,
    output logic [31:0] m_out_seq_status,
    output logic [15:0] m_out_handle,
    output logic [3:0]  m_occupancy,
    output logic [31:0] m_drop_total
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SCN_W = $clog2(QUEUE_DEPTH);
    localparam int HCOPY = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
    localparam int OCC_W = (CNT_W < 4) ? CNT_W : 4;
    localparam logic [SCN_W-1:0] SCAN_LAST = SCN_W'(QUEUE_DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_APPLY = 3'b100
    } state_t;

    state_t                 state_reg;
    logic [SCN_W-1:0]       scan_cnt_reg;
    logic [1:0]             cmd_reg;
    logic [1:0]             kind_reg;
    logic [31:0]            corr_reg;
    logic [31:0]            seq_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [31:0]            stamp_reg;
    logic [CNT_W-1:0]       used_reg;
    logic [31:0]            drops_reg;

    logic        m_valid_reg;
    logic        success_reg;
    logic        displaced_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_corr_reg;
    logic [31:0] out_seq_reg;
    logic [15:0] out_handle_reg;
    logic [3:0]  occ_reg;

    logic                   free_ok_w   [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]       free_idx_w  [QUEUE_DEPTH+1];
    psq_pkg::rank_t         hi_w        [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]       hi_idx_w    [QUEUE_DEPTH+1];
    logic [31:0]            hi_corr_w   [QUEUE_DEPTH+1];
    logic [31:0]            hi_seq_w    [QUEUE_DEPTH+1];
    logic [HANDLE_BITS-1:0] hi_handle_w [QUEUE_DEPTH+1];
    psq_pkg::rank_t         lo_w        [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]       lo_idx_w    [QUEUE_DEPTH+1];

    logic [QUEUE_DEPTH-1:0] sel;
    psq_pkg::ctl_t          ctl;

    logic                   s_fire;
    logic                   can_emit;
    logic                   apply_go;
    logic [1:0]             kind_in;
    logic [HANDLE_BITS-1:0] handle_in;
    logic                   is_push;
    logic                   push_free;
    logic                   push_evict;
    logic                   do_pop;
    logic [IDX_W-1:0]       wr_idx;
    logic [CNT_W-1:0]       used_next;
    logic [31:0]            drops_next;
    logic [3:0]             occ_next;
    logic [15:0]            pop_handle;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign can_emit = !m_valid_reg || m_ready;
    assign apply_go = (state_reg == ST_APPLY) && can_emit;

    always_comb begin
        kind_in = (s_frame_kind == psq_pkg::KIND_INVALID) ? psq_pkg::KIND_STREAM
                                                          : s_frame_kind;
        handle_in = '0;
        for (int b = 0; b < HCOPY; b++) begin
            handle_in[b] = s_frame_handle[b];
        end
    end

    assign free_ok_w[0]   = 1'b0;
    assign free_idx_w[0]  = '0;
    assign hi_w[0]        = '0;
    assign hi_idx_w[0]    = '0;
    assign hi_corr_w[0]   = '0;
    assign hi_seq_w[0]    = '0;
    assign hi_handle_w[0] = '0;
    assign lo_w[0]        = '0;
    assign lo_idx_w[0]    = '0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        psq_cell #(
            .QUEUE_DEPTH (QUEUE_DEPTH),
            .HANDLE_BITS (HANDLE_BITS),
            .CELL_IDX    (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .sel         (sel[i]),
            .ctl         (ctl),
            .wr_kind     (kind_reg),
            .wr_stamp    (stamp_reg),
            .wr_corr     (corr_reg),
            .wr_seq      (seq_reg),
            .wr_handle   (handle_reg),
            .now_stamp   (stamp_reg),
            .free_ok_i   (free_ok_w[i]),
            .free_idx_i  (free_idx_w[i]),
            .hi_i        (hi_w[i]),
            .hi_idx_i    (hi_idx_w[i]),
            .hi_corr_i   (hi_corr_w[i]),
            .hi_seq_i    (hi_seq_w[i]),
            .hi_handle_i (hi_handle_w[i]),
            .lo_i        (lo_w[i]),
            .lo_idx_i    (lo_idx_w[i]),
            .free_ok_o   (free_ok_w[i+1]),
            .free_idx_o  (free_idx_w[i+1]),
            .hi_o        (hi_w[i+1]),
            .hi_idx_o    (hi_idx_w[i+1]),
            .hi_corr_o   (hi_corr_w[i+1]),
            .hi_seq_o    (hi_seq_w[i+1]),
            .hi_handle_o (hi_handle_w[i+1]),
            .lo_o        (lo_w[i+1]),
            .lo_idx_o    (lo_idx_w[i+1])
        );
    end

    always_comb begin
        is_push    = (cmd_reg == psq_pkg::CMD_PUSH);
        push_free  = is_push && free_ok_w[QUEUE_DEPTH];
        push_evict = is_push && !free_ok_w[QUEUE_DEPTH] && lo_w[QUEUE_DEPTH].ok &&
                     (lo_w[QUEUE_DEPTH].kind > kind_reg);
        do_pop     = (cmd_reg == psq_pkg::CMD_POP) && hi_w[QUEUE_DEPTH].ok;
        wr_idx     = push_free ? free_idx_w[QUEUE_DEPTH] : lo_idx_w[QUEUE_DEPTH];

        ctl.wr  = apply_go && (push_free || push_evict);
        ctl.rm  = apply_go && do_pop;
        ctl.clr = apply_go && (cmd_reg == psq_pkg::CMD_CLEAR);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            sel[i] = (ctl.wr && (wr_idx == IDX_W'(i))) ||
                     (ctl.rm && (hi_idx_w[QUEUE_DEPTH] == IDX_W'(i)));
        end

        used_next = used_reg;
        if (cmd_reg == psq_pkg::CMD_CLEAR) begin
            used_next = '0;
        end else if (push_free) begin
            used_next = used_reg + CNT_W'(1);
        end else if (do_pop && (used_reg != '0)) begin
            used_next = used_reg - CNT_W'(1);
        end

        drops_next = drops_reg;
        if (is_push && !push_free && (drops_reg != '1)) begin
            drops_next = drops_reg + 32'd1;
        end

        occ_next = '0;
        for (int b = 0; b < OCC_W; b++) begin
            occ_next[b] = used_next[b];
        end
        pop_handle = '0;
        for (int b = 0; b < HCOPY; b++) begin
            pop_handle[b] = hi_handle_w[QUEUE_DEPTH][b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            stamp_reg    <= '0;
            used_reg     <= '0;
            drops_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        state_reg    <= ST_SCAN;
                        scan_cnt_reg <= '0;
                    end
                end
                ST_SCAN: begin
                    scan_cnt_reg <= scan_cnt_reg + SCN_W'(1);
                    if (scan_cnt_reg == SCAN_LAST) begin
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    if (can_emit) begin
                        state_reg <= ST_IDLE;
                        used_reg  <= used_next;
                        drops_reg <= drops_next;
                        if (ctl.wr) begin
                            stamp_reg <= stamp_reg + 32'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (apply_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg    <= s_command;
            kind_reg   <= kind_in;
            corr_reg   <= s_frame_correlation;
            seq_reg    <= s_frame_seq_status;
            handle_reg <= handle_in;
        end
        if (apply_go) begin
            success_reg    <= ctl.wr || ctl.rm || ctl.clr;
            displaced_reg  <= push_evict;
            out_kind_reg   <= do_pop ? hi_w[QUEUE_DEPTH].kind : 2'd0;
            out_corr_reg   <= do_pop ? hi_corr_w[QUEUE_DEPTH] : 32'd0;
            out_seq_reg    <= do_pop ? hi_seq_w[QUEUE_DEPTH] : 32'd0;
            out_handle_reg <= do_pop ? pop_handle : 16'd0;
            occ_reg        <= occ_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_success         = success_reg;
    assign m_displaced       = displaced_reg;
    assign m_out_kind        = out_kind_reg;
    assign m_out_correlation = out_corr_reg;
    assign m_out_seq_status  = out_seq_reg;
    assign m_out_handle      = out_handle_reg;
    assign m_occupancy       = occ_reg;
    assign m_drop_total      = drops_reg;

endmodule

FILE: hw/rtl/psq_checker.sv
`include "priority_slot_queue_with_eviction_top_macros.svh"

module psq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_success,
    input logic        m_displaced,
    input logic [1:0]  m_out_kind,
    input logic [15:0] m_out_handle,
    input logic [31:0] m_drop_total
);

    `PSQ_ASSERT(a_hold_result, m_valid && !m_ready |=> m_valid && $stable(m_drop_total), "result dropped or changed while stalled")
    `PSQ_ASSERT(a_one_item, s_valid && s_ready |=> !s_ready, "second item taken while one is in work")
    `PSQ_ASSERT(a_displace_ok, m_valid && m_displaced |-> m_success, "displacement without a stored item")
    `PSQ_ASSERT(a_fail_clean, m_valid && !m_success |-> (m_out_kind == 2'd0) && (m_out_handle == 16'd0), "failed item carries frame fields")

endmodule

bind priority_slot_queue_with_eviction_top psq_checker u_psq_checker (.*);
